@@ rtl/core/fit_strategy_block_allocator_macros.svh @@
// ----------------------------------------------------------------------------
// fit_strategy_block_allocator_macros
// assertion macros used by the allocator datapath
// ----------------------------------------------------------------------------
`ifndef FIT_STRATEGY_BLOCK_ALLOCATOR_MACROS_SVH
`define FIT_STRATEGY_BLOCK_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS
// property that must hold at every clock edge out of reset
`define FSBA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("fsba assertion failed");
// condition a implies b at the next edge
`define FSBA_ASSERT_NEXT(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
    else $error("fsba assertion failed");
`else
`define FSBA_ASSERT(lbl, clk, rstn, prop)
`define FSBA_ASSERT_NEXT(lbl, clk, rstn, a, b)
`endif

`endif

@@ rtl/core/fsba_pkg.sv @@
// ----------------------------------------------------------------------------
// fsba_pkg
// types, constants and codes of the fit strategy block allocator
// ----------------------------------------------------------------------------
package fsba_pkg;

  localparam int unsigned POOL_UNITS = 128;
  localparam int unsigned OWNER_BITS = 16;
  localparam int unsigned IDX_W      = $clog2(POOL_UNITS);
  localparam int unsigned CNT_W      = $clog2(POOL_UNITS + 1);
  localparam int unsigned SIZE_W     = CNT_W;

  // request kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // fit strategy codes, anything else acts as worst fit
  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  // result status codes
  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_NO_FIT   = 2'd1;
  localparam logic [1:0] ST_NO_OWNER = 2'd2;

  // register index as seen on paddr bit 2
  localparam logic REG_FIT_STRATEGY = 1'b0;

  typedef struct packed {
    logic        kind;
    logic [7:0]  request_units;
    logic [15:0] owner_tag;
  } in_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [6:0] start_unit;
    logic [7:0] ext_frag;
    logic [7:0] peak_fragmentation;
  } out_res_t;

  typedef struct packed {
    logic [IDX_W-1:0]      start;
    logic [SIZE_W-1:0]     size;
    logic                  is_free;
    logic [OWNER_BITS-1:0] owner;
  } entry_t;

  localparam entry_t RESET_ENTRY = '{
    start:   '0,
    size:    SIZE_W'(POOL_UNITS),
    is_free: 1'b1,
    owner:   '0
  };

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic scan_run;
    logic plan;
    logic move_run;
    logic wr1;
    logic wr2;
    logic fload;
    logic frag_run;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic eng_busy;
    logic found;
    logic split;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/core/fsba_ctrl.sv @@
// ----------------------------------------------------------------------------
// fsba_ctrl
// sequencer that steps the datapath through scan, move, write and rescan
// ----------------------------------------------------------------------------
module fsba_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  fsba_pkg::sts_t sts_i,
  output fsba_pkg::cmd_t cmd_o
);
  import fsba_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_SCAN   = 9'b000000010,
    S_DECIDE = 9'b000000100,
    S_MOVE   = 9'b000001000,
    S_WR1    = 9'b000010000,
    S_WR2    = 9'b000100000,
    S_FLOAD  = 9'b001000000,
    S_FRAG   = 9'b010000000,
    S_FIN    = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_run = 1'b1;
        if (!sts_i.eng_busy) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts_i.found) begin
          cmd_o.plan = 1'b1;
          state_d    = S_MOVE;
        end else begin
          state_d = S_FLOAD;
        end
      end
      S_MOVE: begin
        cmd_o.move_run = 1'b1;
        if (!sts_i.eng_busy) state_d = S_WR1;
      end
      S_WR1: begin
        cmd_o.wr1 = 1'b1;
        state_d   = sts_i.split ? S_WR2 : S_FLOAD;
      end
      S_WR2: begin
        cmd_o.wr2 = 1'b1;
        state_d   = S_FLOAD;
      end
      S_FLOAD: begin
        cmd_o.fload = 1'b1;
        state_d     = S_FRAG;
      end
      S_FRAG: begin
        cmd_o.frag_run = 1'b1;
        if (!sts_i.eng_busy) state_d = S_FIN;
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/core/fsba_datapath.sv @@
// ----------------------------------------------------------------------------
// fsba_datapath
// block table memory, read engine, pick logic, table rewrite and fragmentation
// ----------------------------------------------------------------------------
`include "fit_strategy_block_allocator_macros.svh"

module fsba_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        fit_i,
  input  fsba_pkg::in_req_t in_req_i,
  input  fsba_pkg::cmd_t    cmd_i,
  output fsba_pkg::sts_t    sts_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output fsba_pkg::out_res_t out_res_o
);
  import fsba_pkg::*;

  entry_t mem [POOL_UNITS];

  entry_t           rdata_q;
  logic             ovr_q;
  logic             e0_q;
  logic             rvld_q;
  logic [IDX_W-1:0] ridx_q;
  logic [IDX_W-1:0] ptr_q;
  logic [CNT_W-1:0] left_q;
  logic             dn_q;

  logic [CNT_W-1:0] cnt_q;
  logic [SIZE_W-1:0] peak_q;
  in_req_t          req_q;
  logic             found_q;
  logic [IDX_W-1:0] pick_q;
  entry_t           pick_ent_q;
  entry_t           last_ent_q;
  entry_t           prev_ent_q;
  entry_t           next_ent_q;
  logic             pf_q;
  logic             nf_q;
  logic             split_q;
  logic [SIZE_W-1:0] total_q;
  logic [SIZE_W-1:0] largest_q;
  logic             out_valid_q;
  out_res_t         out_res_q;

  entry_t           rd_ent;
  logic             rd_issue;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;
  logic             fit_ok;
  logic             better;
  logic             split_c;
  logic [1:0]       merge_r;
  logic [SIZE_W:0]  merge_sum;
  logic [SIZE_W-1:0] frag_c;

  assign rd_ent   = ovr_q ? RESET_ENTRY : rdata_q;
  assign rd_issue = (cmd_i.scan_run | cmd_i.move_run | cmd_i.frag_run) && (left_q != '0);
  assign merge_r  = {1'b0, pf_q} + {1'b0, nf_q};
  assign split_c  = (pick_ent_q.size > req_q.request_units) &&
                    (cnt_q < CNT_W'(POOL_UNITS));

  // candidate test for allocate scan
  assign fit_ok = rd_ent.is_free && (rd_ent.size >= req_q.request_units) &&
                  (req_q.request_units != '0);
  always_comb begin
    if (!found_q) begin
      better = 1'b1;
    end else if (fit_i == FIT_BEST) begin
      better = rd_ent.size < pick_ent_q.size;
    end else if (fit_i == FIT_FIRST) begin
      better = 1'b0;
    end else begin
      better = rd_ent.size > pick_ent_q.size;
    end
  end

  assign merge_sum = {1'b0, pick_ent_q.size} +
                     (pf_q ? {1'b0, prev_ent_q.size} : '0) +
                     (nf_q ? {1'b0, next_ent_q.size} : '0);

  // table write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pick_q;
    wr_data = rd_ent;
    if (cmd_i.move_run && rvld_q) begin
      wr_en   = 1'b1;
      wr_addr = dn_q ? ridx_q + IDX_W'(1) : ridx_q - IDX_W'(merge_r);
      wr_data = rd_ent;
    end else if (cmd_i.wr1) begin
      wr_en = 1'b1;
      if (req_q.kind == KIND_ALLOC) begin
        wr_addr = pick_q;
        wr_data = '{start: pick_ent_q.start,
                    size: split_q ? req_q.request_units : pick_ent_q.size,
                    is_free: 1'b0,
                    owner: req_q.owner_tag[OWNER_BITS-1:0]};
      end else begin
        wr_addr = pick_q - IDX_W'(pf_q);
        wr_data = '{start: pf_q ? prev_ent_q.start : pick_ent_q.start,
                    size: merge_sum[SIZE_W-1:0],
                    is_free: 1'b1,
                    owner: '0};
      end
    end else if (cmd_i.wr2) begin
      wr_en   = 1'b1;
      wr_addr = pick_q + IDX_W'(1);
      wr_data = '{start: pick_ent_q.start + req_q.request_units[IDX_W-1:0],
                  size: pick_ent_q.size - req_q.request_units,
                  is_free: 1'b1,
                  owner: '0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_issue) rdata_q <= mem[ptr_q];
  end

  assign frag_c = total_q - largest_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovr_q       <= 1'b0;
      e0_q        <= 1'b1;
      rvld_q      <= 1'b0;
      ridx_q      <= '0;
      ptr_q       <= '0;
      left_q      <= '0;
      dn_q        <= 1'b0;
      cnt_q       <= CNT_W'(1);
      peak_q      <= '0;
      req_q       <= '0;
      found_q     <= 1'b0;
      pick_q      <= '0;
      pick_ent_q  <= '0;
      last_ent_q  <= '0;
      prev_ent_q  <= '0;
      next_ent_q  <= '0;
      pf_q        <= 1'b0;
      nf_q        <= 1'b0;
      split_q     <= 1'b0;
      total_q     <= '0;
      largest_q   <= '0;
      out_valid_q <= 1'b0;
      out_res_q   <= '0;
    end else begin
      // read engine
      rvld_q <= rd_issue;
      if (rd_issue) begin
        ridx_q <= ptr_q;
        ovr_q  <= e0_q && (ptr_q == '0);
      end
      if (cmd_i.accept || cmd_i.fload) begin
        ptr_q  <= '0;
        left_q <= cnt_q;
        dn_q   <= 1'b0;
      end else if (cmd_i.plan) begin
        if (req_q.kind == KIND_ALLOC) begin
          ptr_q  <= IDX_W'(cnt_q - CNT_W'(1));
          left_q <= split_c ? cnt_q - CNT_W'(1) - {1'b0, pick_q} : '0;
          dn_q   <= 1'b1;
        end else begin
          ptr_q  <= pick_q + IDX_W'(1) + IDX_W'(nf_q);
          left_q <= cnt_q - CNT_W'(1) - {1'b0, pick_q} - CNT_W'(nf_q);
          dn_q   <= 1'b0;
        end
        split_q <= (req_q.kind == KIND_ALLOC) && split_c;
      end else if (rd_issue) begin
        ptr_q  <= dn_q ? ptr_q - IDX_W'(1) : ptr_q + IDX_W'(1);
        left_q <= left_q - CNT_W'(1);
      end

      if (wr_en && (wr_addr == '0)) e0_q <= 1'b0;

      // request capture
      if (cmd_i.accept) begin
        req_q   <= in_req_i;
        found_q <= 1'b0;
        pf_q    <= 1'b0;
        nf_q    <= 1'b0;
        split_q <= 1'b0;
      end

      // choose or find a block
      if (cmd_i.scan_run && rvld_q) begin
        last_ent_q <= rd_ent;
        if (req_q.kind == KIND_ALLOC) begin
          if (fit_ok && better) begin
            found_q    <= 1'b1;
            pick_q     <= ridx_q;
            pick_ent_q <= rd_ent;
          end
        end else begin
          if (!found_q && !rd_ent.is_free &&
              (rd_ent.owner == req_q.owner_tag[OWNER_BITS-1:0])) begin
            found_q    <= 1'b1;
            pick_q     <= ridx_q;
            pick_ent_q <= rd_ent;
            prev_ent_q <= last_ent_q;
            pf_q       <= (ridx_q != '0) && last_ent_q.is_free;
          end
          if (found_q && ({1'b0, ridx_q} == {1'b0, pick_q} + CNT_W'(1))) begin
            nf_q       <= rd_ent.is_free;
            next_ent_q <= rd_ent;
          end
        end
      end

      // block count follows the rewrite
      if (cmd_i.wr1) begin
        if (req_q.kind == KIND_ALLOC) begin
          cnt_q <= cnt_q + CNT_W'(split_q);
        end else begin
          cnt_q <= cnt_q - CNT_W'(merge_r);
        end
      end

      // fragmentation rescan
      if (cmd_i.fload) begin
        total_q   <= '0;
        largest_q <= '0;
      end else if (cmd_i.frag_run && rvld_q && rd_ent.is_free) begin
        total_q <= total_q + rd_ent.size;
        if (rd_ent.size > largest_q) largest_q <= rd_ent.size;
      end

      // result register
      if (cmd_i.finish) begin
        out_valid_q        <= 1'b1;
        out_res_q.ext_frag <= frag_c;
        if (found_q) begin
          out_res_q.status     <= ST_DONE;
          out_res_q.start_unit <= (req_q.kind == KIND_ALLOC) ? pick_ent_q.start : '0;
          out_res_q.peak_fragmentation <= (frag_c > peak_q) ? frag_c : peak_q;
          if (frag_c > peak_q) peak_q <= frag_c;
        end else begin
          out_res_q.status <= (req_q.kind == KIND_ALLOC) ? ST_NO_FIT : ST_NO_OWNER;
          out_res_q.start_unit <= '0;
          out_res_q.peak_fragmentation <= peak_q;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.eng_busy = (left_q != '0) || rvld_q;
  assign sts_o.found    = found_q;
  assign sts_o.split    = split_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  `FSBA_ASSERT(a_cnt_range, clk_i, rst_ni, (cnt_q != '0) && (cnt_q <= CNT_W'(POOL_UNITS)))
  `FSBA_ASSERT_NEXT(a_e0_clear, clk_i, rst_ni, wr_en && (wr_addr == '0), !e0_q)
  `FSBA_ASSERT(a_finish_free, clk_i, rst_ni, !cmd_i.finish || !out_valid_q || out_ready_i)
  `FSBA_ASSERT(a_no_write_scan, clk_i, rst_ni, !(wr_en && (cmd_i.scan_run || cmd_i.frag_run)))

endmodule

@@ rtl/core/fit_strategy_block_allocator.sv @@
// ----------------------------------------------------------------------------
// fit_strategy_block_allocator
// first, best or worst fit block allocator with coalescing on free
// ----------------------------------------------------------------------------
// The pool of 128 units is kept as an address-ordered block table in a
// single-port-read memory. A request is served by passes over the table,
// none reading more entries than the block count (at most 128): one pass
// picks or finds the block, a second pass shifts the entries behind it by
// one read and one write each cycle, and a third pass rebuilds the
// fragmentation figures; the one read port of the table makes each pass
// a serial walk. A finished result also waits while the previous one is
// still held on the output. A new request is taken while the previous
// result waits on the output. The table needs no clearing pass after
// reset: only entry 0 is read before it is written, and a flag makes it
// read as the whole free pool until it is.
module fit_strategy_block_allocator (
  input  logic                clk_i,
  input  logic                rst_ni,
  // request channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  fsba_pkg::in_req_t   in_req_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output fsba_pkg::out_res_t  out_res_o,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import fsba_pkg::*;

  logic [1:0] fit_q;
  cmd_t       cmd;
  sts_t       sts;

  // apb register, paddr bit 2 picks the word, low bits are byte lanes
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_FIT_STRATEGY) ? {30'd0, fit_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_q <= FIT_FIRST;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == REG_FIT_STRATEGY)) begin
      fit_q <= pwdata[1:0];
    end
  end

  // sequencer
  fsba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // table, pick logic and result register
  fsba_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fit_i       (fit_q),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (out_res_o)
  );

endmodule

@@ verif/fit_strategy_block_allocator_test.sv @@
// ----------------------------------------------------------------------------
// fit_strategy_block_allocator_test
// self-checking bench: allocate and free requests under every fit strategy,
// results checked against a behavioral model of the block table
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

// behavioral model of the allocator plus the queue of results still due
class alloc_scoreboard;
  typedef struct {
    int unsigned base;
    int unsigned units;
    bit          avail;
    int unsigned tag;
  } span_t;

  span_t                 spans[$];
  int unsigned           peak;
  logic [1:0]            strategy;
  fsba_pkg::out_res_t    due[$];
  int                    errors;

  function void clear();
    span_t s;
    s.base = 0; s.units = fsba_pkg::POOL_UNITS; s.avail = 1; s.tag = 0;
    spans = {};
    spans.push_back(s);
    peak = 0;
    strategy = fsba_pkg::FIT_FIRST;
    due = {};
    errors = 0;
  endfunction

  function int unsigned frag();
    int unsigned tot, big;
    tot = 0; big = 0;
    foreach (spans[i]) if (spans[i].avail) begin
      tot += spans[i].units;
      if (spans[i].units > big) big = spans[i].units;
    end
    return tot - big;
  endfunction

  function int choose(int unsigned n);
    int pick;
    pick = -1;
    foreach (spans[i]) begin
      if (!spans[i].avail || spans[i].units < n) continue;
      if (strategy == fsba_pkg::FIT_FIRST) return i;
      if (pick < 0) pick = i;
      else if (strategy == fsba_pkg::FIT_BEST) begin
        if (spans[i].units < spans[pick].units) pick = i;
      end else if (spans[i].units > spans[pick].units) pick = i;
    end
    return pick;
  endfunction

  function void note_request(fsba_pkg::in_req_t rq);
    fsba_pkg::out_res_t r;
    span_t rest;
    int k, j;
    int unsigned f;
    r = '0;
    if (rq.kind == fsba_pkg::KIND_ALLOC) begin
      k = (rq.request_units == 0) ? -1 : choose(rq.request_units);
      if (k < 0) r.status = fsba_pkg::ST_NO_FIT;
      else begin
        if (spans[k].units > rq.request_units && spans.size() < fsba_pkg::POOL_UNITS) begin
          rest.base = spans[k].base + rq.request_units;
          rest.units = spans[k].units - rq.request_units;
          rest.avail = 1; rest.tag = 0;
          spans.insert(k + 1, rest);
          spans[k].units = rq.request_units;
        end
        spans[k].avail = 0;
        spans[k].tag = rq.owner_tag;
        r.start_unit = spans[k].base[6:0];
        r.status = fsba_pkg::ST_DONE;
        f = frag(); if (f > peak) peak = f;
      end
    end else begin
      r.status = fsba_pkg::ST_NO_OWNER;
      for (k = 0; k < spans.size(); k++)
        if (!spans[k].avail && spans[k].tag == rq.owner_tag) break;
      if (k < spans.size()) begin
        spans[k].avail = 1; spans[k].tag = 0;
        j = 0;
        while (j + 1 < spans.size()) begin
          if (spans[j].avail && spans[j+1].avail) begin
            spans[j].units += spans[j+1].units;
            spans.delete(j + 1);
          end else j++;
        end
        f = frag(); if (f > peak) peak = f;
        r.status = fsba_pkg::ST_DONE;
      end
    end
    r.ext_frag = frag();
    r.peak_fragmentation = peak;
    due.push_back(r);
  endfunction

  function void check_result(fsba_pkg::out_res_t got);
    fsba_pkg::out_res_t exp;
    if (due.size() == 0) begin
      $error("result with nothing pending: %p", got);
      errors++;
      return;
    end
    exp = due.pop_front();
    if (got.status !== exp.status) begin
      $error("status exp %0d got %0d", exp.status, got.status); errors++;
    end
    if (got.start_unit !== exp.start_unit) begin
      $error("start_unit exp %0d got %0d", exp.start_unit, got.start_unit); errors++;
    end
    if (got.ext_frag !== exp.ext_frag) begin
      $error("ext_frag exp %0d got %0d", exp.ext_frag, got.ext_frag); errors++;
    end
    if (got.peak_fragmentation !== exp.peak_fragmentation) begin
      $error("peak_fragmentation exp %0d got %0d",
             exp.peak_fragmentation, got.peak_fragmentation); errors++;
    end
  endfunction
endclass

module fit_strategy_block_allocator_test;
  import fsba_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  in_req_t    in_req_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  out_res_t   out_res_o;
  logic       psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic       pready;

  alloc_scoreboard board = new();
  int unsigned cycles = 0;
  bit          rx_quiet = 1'b0;   // no stalls on the result side when set
  bit          drain_on = 1'b1;

  fit_strategy_block_allocator u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 400);
  endfunction

  // result side: sample at the rising edge, stall at random
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && out_valid_o && out_ready_i) board.check_result(out_res_o);
  end

  initial begin : result_sink
    int unsigned g;
    forever begin
      @(negedge clk_i);
      if (!drain_on || rx_quiet) out_ready_i <= drain_on;
      else begin
        g = gap_len();
        out_ready_i <= (g == 0);
        repeat (g) @(negedge clk_i);
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    wait (cycles >= CYCLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

  // write the fit strategy over the two-phase config port
  task automatic write_strategy(logic [1:0] s);
    @(negedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {REG_FIT_STRATEGY, 2'b00}; pwdata <= {$urandom} & ~32'h3 | s;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    board.strategy = s;
  endtask

  // one request; held until accepted, then an optional gap
  task automatic send_request(logic kind, logic [7:0] units, logic [15:0] tag);
    in_req_t rq;
    int unsigned g;
    rq.kind = kind; rq.request_units = units; rq.owner_tag = tag;
    in_valid_i <= 1'b1;
    in_req_i <= rq;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_request(rq);
    @(negedge clk_i);
    g = gap_len();
    if (g != 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
  endtask

  // wait until every result is back, then let the block settle
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (board.due.size() == 0);
    repeat (450) @(negedge clk_i);
  endtask

  // random phase: mostly tags from a small live set so frees usually hit
  task automatic random_phase(int unsigned count);
    logic [15:0] tags[$];
    logic [15:0] t;
    int unsigned r, idx;
    for (int unsigned n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        t = (r < 5) ? 16'($urandom) : 16'($urandom_range(0, 31));
        // mostly small sizes, a few large and the odd zero or over-size one
        send_request(KIND_ALLOC, (r < 3) ? 8'($urandom) :
                     (r < 45) ? 8'($urandom_range(1, 16)) : 8'($urandom_range(1, 128)), t);
        tags.push_back(t);
      end else if (r < 92 && tags.size() != 0) begin
        idx = $urandom_range(0, tags.size() - 1);
        send_request(KIND_FREE, 8'($urandom), tags[idx]);
        tags.delete(idx);
      end else begin
        send_request(KIND_FREE, 8'($urandom), 16'($urandom));
      end
    end
  endtask

  initial begin : stimulus
    board.clear();
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: extremes, zero and oversized, unknown owner, coalescing
    send_request(KIND_ALLOC, 8'd0, 16'h0001);
    send_request(KIND_ALLOC, 8'd129, 16'h0001);
    send_request(KIND_ALLOC, 8'd255, 16'h0001);
    send_request(KIND_FREE, 8'd0, 16'hFFFF);
    send_request(KIND_ALLOC, 8'd128, 16'hFFFF);
    send_request(KIND_ALLOC, 8'd1, 16'h0000);
    send_request(KIND_FREE, 8'd255, 16'hFFFF);
    send_request(KIND_ALLOC, 8'd10, 16'hA5A5);
    send_request(KIND_ALLOC, 8'd20, 16'h5A5A);
    send_request(KIND_ALLOC, 8'd5, 16'h1234);
    send_request(KIND_ALLOC, 8'd30, 16'h5A5A);
    send_request(KIND_FREE, 8'd0, 16'hA5A5);
    send_request(KIND_FREE, 8'd0, 16'h5A5A);   // lowest-addressed match first
    send_request(KIND_ALLOC, 8'd8, 16'h0042);
    send_request(KIND_FREE, 8'd0, 16'h1234);
    send_request(KIND_FREE, 8'd0, 16'h5A5A);
    send_request(KIND_FREE, 8'd0, 16'h0042);
    send_request(KIND_FREE, 8'd0, 16'h0000);
    settle();

    // strategies in turn, including code three, fully random phases between
    rx_quiet = 1'b1;
    write_strategy(FIT_BEST);
    random_phase(60);
    settle();
    rx_quiet = 1'b0;
    write_strategy(FIT_WORST);
    random_phase(120);
    settle();
    write_strategy(2'd3);   // unnamed code, behaves as worst fit
    random_phase(100);
    settle();
    write_strategy(FIT_FIRST);
    random_phase(120);
    settle();
    write_strategy(FIT_BEST);
    random_phase(100);
    settle();

    if (board.errors == 0 && board.due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
